// ===== sv/vmlt_pkg.sv =====
package vmlt_pkg;

    localparam int TABLE_ENTRIES   = 64;
    localparam int PORTS_PER_ENTRY = 4;
    localparam int PORT_COUNT      = 64;

    localparam int MODE_W  = 3;
    localparam int VLAN_W  = 12;
    localparam int MAC_W   = 48;
    localparam int PORT_W  = 6;
    localparam int IP_W    = 32;
    localparam int AGE_W   = 20;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 7;
    localparam int MASK_W  = 64;

    localparam logic [AGE_W-1:0] AGING_RESET = AGE_W'(300000);

    localparam logic [MODE_W-1:0] MODE_LEARN    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEL_PORT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_ENT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_PORT_ABS  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_SLOT   = 3'd4;

    localparam logic CFG_MASK  = 1'b0;
    localparam logic CFG_AGING = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [VLAN_W-1:0] vlan;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   ip;
        logic              make_static;
        logic              insert;
        logic [AGE_W-1:0]  aging;
    } t_cmd;

    typedef struct packed {
        logic              go;
        logic              found;
        logic              placed;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  cnt;
    } t_link;

    typedef struct packed {
        logic                                  is_static;
        logic [AGE_W-1:0]                      age;
        logic [PORTS_PER_ENTRY-1:0]            slot_valid;
        logic [PORTS_PER_ENTRY-1:0][PORT_W-1:0] slot_port;
        logic [PORTS_PER_ENTRY-1:0][IP_W-1:0]   slot_ip;
    } t_view;

endpackage

// ===== sv/vmlt_cell.sv =====
module vmlt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vmlt_pkg::t_cmd  i_cmd,
    input  vmlt_pkg::t_link i_link,
    output vmlt_pkg::t_link o_link,
    output vmlt_pkg::t_view o_view
);

    localparam int PPE = vmlt_pkg::PORTS_PER_ENTRY;

    logic                                          r_valid, n_valid;
    logic [vmlt_pkg::VLAN_W-1:0]                   r_vlan, n_vlan;
    logic [vmlt_pkg::MAC_W-1:0]                    r_mac, n_mac;
    logic                                          r_static, n_static;
    logic [vmlt_pkg::AGE_W-1:0]                    r_age, n_age;
    logic [PPE-1:0]                                r_sv, n_sv;
    logic [PPE-1:0][vmlt_pkg::PORT_W-1:0]          r_sp, n_sp;
    logic [PPE-1:0][vmlt_pkg::IP_W-1:0]            r_sip, n_sip;
    vmlt_pkg::t_link                               r_link, n_link;

    logic           match;
    logic           port_held;
    logic [PPE-1:0] free_oh;
    logic [PPE-1:0] del_oh;
    logic           seen_free, seen_del;

    assign match = r_valid && (r_vlan == i_cmd.vlan) && (r_mac == i_cmd.mac);

    always_comb begin
        port_held = 1'b0;
        seen_free = 1'b0;
        seen_del  = 1'b0;
        free_oh   = '0;
        del_oh    = '0;
        for (int s = 0; s < PPE; s++) begin
            if (r_sv[s] && r_sp[s] == i_cmd.port) begin
                port_held = 1'b1;
            end
            if (!r_sv[s] && !seen_free) begin
                free_oh[s] = 1'b1;
                seen_free  = 1'b1;
            end
            if (r_sv[s] && r_sp[s] == i_cmd.port && r_sip[s] == i_cmd.ip && !seen_del) begin
                del_oh[s] = 1'b1;
                seen_del  = 1'b1;
            end
        end
    end

    always_comb begin
        n_valid  = r_valid;
        n_vlan   = r_vlan;
        n_mac    = r_mac;
        n_static = r_static;
        n_age    = r_age;
        n_sv     = r_sv;
        n_sp     = r_sp;
        n_sip    = r_sip;
        n_link   = i_link;
        if (i_link.go) begin
            unique case (i_cmd.mode)
                vmlt_pkg::MODE_LEARN: begin
                    if (i_cmd.insert) begin
                        if (!r_valid && !i_link.placed) begin
                            n_valid     = 1'b1;
                            n_vlan      = i_cmd.vlan;
                            n_mac       = i_cmd.mac;
                            n_static    = i_cmd.make_static;
                            n_age       = i_cmd.make_static ? '0 : i_cmd.aging;
                            n_sv        = PPE'(1);
                            n_sp        = '0;
                            n_sip       = '0;
                            n_sp[0]     = i_cmd.port;
                            n_sip[0]    = i_cmd.ip;
                            n_link.placed = 1'b1;
                        end
                    end else if (match) begin
                        n_link.found = 1'b1;
                        if (port_held) begin
                            n_link.status = vmlt_pkg::ST_OK;
                        end else if (seen_free) begin
                            n_link.status = vmlt_pkg::ST_OK;
                            for (int s = 0; s < PPE; s++) begin
                                if (free_oh[s]) begin
                                    n_sv[s]  = 1'b1;
                                    n_sp[s]  = i_cmd.port;
                                    n_sip[s] = i_cmd.ip;
                                end
                            end
                        end else begin
                            n_link.status = vmlt_pkg::ST_NO_SLOT;
                        end
                    end
                end
                vmlt_pkg::MODE_DEL_PORT: begin
                    if (match) begin
                        n_link.found = 1'b1;
                        n_sv         = r_sv & ~del_oh;
                        if ((r_sv & ~del_oh) == '0) begin
                            n_valid = 1'b0;
                        end
                    end
                end
                vmlt_pkg::MODE_DEL_ENT: begin
                    if (match) begin
                        n_link.found = 1'b1;
                        n_valid      = 1'b0;
                    end
                end
                vmlt_pkg::MODE_LOOKUP: begin
                    if (match) begin
                        n_link.found = 1'b1;
                    end
                end
                vmlt_pkg::MODE_CLEAR: begin
                    if (r_valid && !r_static) begin
                        n_valid    = 1'b0;
                        n_link.cnt = i_link.cnt + vmlt_pkg::CNT_W'(1);
                    end
                end
                vmlt_pkg::MODE_TICK: begin
                    if (r_valid && !r_static) begin
                        if (r_age <= vmlt_pkg::AGE_W'(1)) begin
                            n_valid    = 1'b0;
                            n_link.cnt = i_link.cnt + vmlt_pkg::CNT_W'(1);
                        end else begin
                            n_age = r_age - vmlt_pkg::AGE_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_view = '0;
        if (i_link.go && match && i_cmd.mode == vmlt_pkg::MODE_LOOKUP) begin
            o_view.is_static  = r_static;
            o_view.age        = r_static ? '0 : r_age;
            o_view.slot_valid = r_sv;
            o_view.slot_port  = r_sp;
            o_view.slot_ip    = r_sip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_link  <= '0;
        end else begin
            r_valid <= n_valid;
            r_link  <= n_link;
        end
        r_vlan   <= n_vlan;
        r_mac    <= n_mac;
        r_static <= n_static;
        r_age    <= n_age;
        r_sv     <= n_sv;
        r_sp     <= n_sp;
        r_sip    <= n_sip;
    end

    assign o_link = r_link;

endmodule

// ===== sv/vlan_mac_learning_table.sv =====
// Layer-2 forwarding table keyed by VLAN and MAC, built as a row of TABLE_ENTRIES cells, one
// entry per cell. A command passes down the row one cell per clock; learning a new key
// needs a second pass to claim the first free entry, and a lookup that finds its key
// returns one result per valid slot. Learning to an absent port is answered without a pass.
// One item is in flight at a time; a finished result may wait in the output register while the
// next item is taken.
module vlan_mac_learning_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [vmlt_pkg::MASK_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [vmlt_pkg::MODE_W-1:0]       i_mode,
    input  logic [vmlt_pkg::VLAN_W-1:0]       i_vlan,
    input  logic [vmlt_pkg::MAC_W-1:0]        i_mac_address,
    input  logic [vmlt_pkg::PORT_W-1:0]       i_port_index,
    input  logic [vmlt_pkg::IP_W-1:0]         i_remote_ip,
    input  logic                              i_make_static,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [vmlt_pkg::STAT_W-1:0]       o_status,
    output logic                              o_entry_static,
    output logic [vmlt_pkg::AGE_W-1:0]        o_time_left,
    output logic [vmlt_pkg::PORT_W-1:0]       o_out_port,
    output logic [vmlt_pkg::IP_W-1:0]         o_out_remote_ip,
    output logic                              o_port_valid,
    output logic [vmlt_pkg::CNT_W-1:0]        o_removed_count,
    output logic                              o_last
);

    localparam int N   = vmlt_pkg::TABLE_ENTRIES;
    localparam int PPE = vmlt_pkg::PORTS_PER_ENTRY;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0]                    r_state, n_state;
    vmlt_pkg::t_cmd                r_cmd, n_cmd;
    logic                          r_launch, n_launch;
    vmlt_pkg::t_view               r_view, n_view;
    logic [vmlt_pkg::STAT_W-1:0]   r_status, n_status;
    logic [vmlt_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_multi, n_multi;
    logic [PPE-1:0]                r_pend, n_pend;
    logic [vmlt_pkg::MASK_W-1:0]   r_mask;
    logic [vmlt_pkg::AGE_W-1:0]    r_aging;

    logic                          r_ovalid, n_ovalid;
    logic [vmlt_pkg::STAT_W-1:0]   r_o_status, n_o_status;
    logic                          r_o_static, n_o_static;
    logic [vmlt_pkg::AGE_W-1:0]    r_o_time, n_o_time;
    logic [vmlt_pkg::PORT_W-1:0]   r_o_port, n_o_port;
    logic [vmlt_pkg::IP_W-1:0]     r_o_ip, n_o_ip;
    logic                          r_o_pv, n_o_pv;
    logic [vmlt_pkg::CNT_W-1:0]    r_o_cnt, n_o_cnt;
    logic                          r_o_last, n_o_last;

    vmlt_pkg::t_link               w_link [N+1];
    vmlt_pkg::t_view               w_view [N];
    vmlt_pkg::t_view               view_or;
    vmlt_pkg::t_link               tail;
    logic                          out_free;
    logic                          port_absent;
    logic [PPE-1:0]                pick_oh;
    logic                          picked;

    assign w_link[0] = '{go: r_launch, found: 1'b0, placed: 1'b0,
                         status: vmlt_pkg::ST_OK, cnt: '0};

    for (genvar g = 0; g < N; g++) begin : g_cell
        vmlt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (r_cmd),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_view  (w_view[g])
        );
    end

    always_comb begin
        view_or = '0;
        for (int i = 0; i < N; i++) begin
            view_or = view_or | w_view[i];
        end
    end

    assign tail        = w_link[N];
    assign out_free    = !r_ovalid || !i_out_stall;
    assign port_absent = (32'(i_port_index) >= vmlt_pkg::PORT_COUNT) || !r_mask[i_port_index];

    always_comb begin
        picked  = 1'b0;
        pick_oh = '0;
        for (int s = 0; s < PPE; s++) begin
            if (r_pend[s] && !picked) begin
                pick_oh[s] = 1'b1;
                picked     = 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_launch   = 1'b0;
        n_view     = r_view;
        n_status   = r_status;
        n_cnt      = r_cnt;
        n_multi    = r_multi;
        n_pend     = r_pend;
        n_ovalid   = r_ovalid && i_out_stall;
        n_o_status = r_o_status;
        n_o_static = r_o_static;
        n_o_time   = r_o_time;
        n_o_port   = r_o_port;
        n_o_ip     = r_o_ip;
        n_o_pv     = r_o_pv;
        n_o_cnt    = r_o_cnt;
        n_o_last   = r_o_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.mode        = i_mode;
                    n_cmd.vlan        = i_vlan;
                    n_cmd.mac         = i_mac_address;
                    n_cmd.port        = i_port_index;
                    n_cmd.ip          = i_remote_ip;
                    n_cmd.make_static = i_make_static;
                    n_cmd.insert      = 1'b0;
                    n_cmd.aging       = r_aging;
                    n_view            = '0;
                    n_cnt             = '0;
                    n_multi           = 1'b0;
                    if (i_mode == vmlt_pkg::MODE_LEARN && port_absent) begin
                        n_status = vmlt_pkg::ST_PORT_ABS;
                        n_state  = S_EMIT;
                    end else begin
                        n_launch = 1'b1;
                        n_state  = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                n_view = r_view | view_or;
                if (tail.go) begin
                    n_cnt    = tail.cnt;
                    n_status = vmlt_pkg::ST_OK;
                    n_state  = S_EMIT;
                    case (r_cmd.mode)
                        vmlt_pkg::MODE_LEARN: begin
                            if (r_cmd.insert) begin
                                n_status = tail.placed ? vmlt_pkg::ST_OK : vmlt_pkg::ST_FULL;
                            end else if (tail.found) begin
                                n_status = tail.status;
                            end else begin
                                n_cmd.insert = 1'b1;
                                n_launch     = 1'b1;
                                n_state      = S_SWEEP;
                            end
                        end
                        vmlt_pkg::MODE_DEL_PORT, vmlt_pkg::MODE_DEL_ENT: begin
                            n_status = tail.found ? vmlt_pkg::ST_OK : vmlt_pkg::ST_NOT_FOUND;
                        end
                        vmlt_pkg::MODE_LOOKUP: begin
                            n_status = tail.found ? vmlt_pkg::ST_OK : vmlt_pkg::ST_NOT_FOUND;
                            n_multi  = tail.found && (r_view.slot_valid != '0);
                            n_pend   = r_view.slot_valid;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_static = 1'b0;
                    n_o_time   = '0;
                    n_o_port   = '0;
                    n_o_ip     = '0;
                    n_o_pv     = 1'b0;
                    n_o_cnt    = r_cnt;
                    n_o_last   = 1'b1;
                    if (r_multi) begin
                        n_o_static = r_view.is_static;
                        n_o_time   = r_view.age;
                        n_o_pv     = 1'b1;
                        for (int s = 0; s < PPE; s++) begin
                            if (pick_oh[s]) begin
                                n_o_port = r_view.slot_port[s];
                                n_o_ip   = r_view.slot_ip[s];
                            end
                        end
                        n_pend   = r_pend & ~pick_oh;
                        n_o_last = ((r_pend & ~pick_oh) == '0);
                        if ((r_pend & ~pick_oh) == '0) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_ovalid <= 1'b0;
            r_mask   <= '0;
            r_aging  <= vmlt_pkg::AGING_RESET;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    vmlt_pkg::CFG_MASK:  r_mask  <= i_cfg_data;
                    vmlt_pkg::CFG_AGING: r_aging <= i_cfg_data[vmlt_pkg::AGE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_cmd      <= n_cmd;
        r_view     <= n_view;
        r_status   <= n_status;
        r_cnt      <= n_cnt;
        r_multi    <= n_multi;
        r_pend     <= n_pend;
        r_o_status <= n_o_status;
        r_o_static <= n_o_static;
        r_o_time   <= n_o_time;
        r_o_port   <= n_o_port;
        r_o_ip     <= n_o_ip;
        r_o_pv     <= n_o_pv;
        r_o_cnt    <= n_o_cnt;
        r_o_last   <= n_o_last;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_status        = r_o_status;
    assign o_entry_static  = r_o_static;
    assign o_time_left     = r_o_time;
    assign o_out_port      = r_o_port;
    assign o_out_remote_ip = r_o_ip;
    assign o_port_valid    = r_o_pv;
    assign o_removed_count = r_o_cnt;
    assign o_last          = r_o_last;

endmodule

// ===== tb/sv/tb_vlan_mac_learning_table.sv =====
module tb_vlan_mac_learning_table;

    localparam logic [vmlt_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [vmlt_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 2 * vmlt_pkg::TABLE_ENTRIES + 20;
    localparam int TE  = vmlt_pkg::TABLE_ENTRIES;
    localparam int PPE = vmlt_pkg::PORTS_PER_ENTRY;

    typedef struct packed {
        logic [vmlt_pkg::MODE_W-1:0] mode;
        logic [vmlt_pkg::VLAN_W-1:0] vlan;
        logic [vmlt_pkg::MAC_W-1:0]  mac;
        logic [vmlt_pkg::PORT_W-1:0] port;
        logic [vmlt_pkg::IP_W-1:0]   ip;
        logic                        make_static;
    } t_fwd_cmd;

    typedef struct packed {
        logic [vmlt_pkg::STAT_W-1:0] status;
        logic                        entry_static;
        logic [vmlt_pkg::AGE_W-1:0]  time_left;
        logic [vmlt_pkg::PORT_W-1:0] port;
        logic [vmlt_pkg::IP_W-1:0]   ip;
        logic                        port_valid;
        logic [vmlt_pkg::CNT_W-1:0]  removed;
        logic                        last;
    } t_fwd_reply;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic                        i_cfg_index = 1'b0;
    logic [vmlt_pkg::MASK_W-1:0] i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [vmlt_pkg::MODE_W-1:0] i_mode = '0;
    logic [vmlt_pkg::VLAN_W-1:0] i_vlan = '0;
    logic [vmlt_pkg::MAC_W-1:0]  i_mac_address = '0;
    logic [vmlt_pkg::PORT_W-1:0] i_port_index = '0;
    logic [vmlt_pkg::IP_W-1:0]   i_remote_ip = '0;
    logic                        i_make_static = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [vmlt_pkg::STAT_W-1:0] o_status;
    logic                        o_entry_static;
    logic [vmlt_pkg::AGE_W-1:0]  o_time_left;
    logic [vmlt_pkg::PORT_W-1:0] o_out_port;
    logic [vmlt_pkg::IP_W-1:0]   o_out_remote_ip;
    logic                        o_port_valid;
    logic [vmlt_pkg::CNT_W-1:0]  o_removed_count;
    logic                        o_last;

    vlan_mac_learning_table i_dut (.*);

    always #2 i_clk = ~i_clk;

    // shadow table
    logic [vmlt_pkg::MASK_W-1:0] mdl_mask = '0;
    logic [vmlt_pkg::AGE_W-1:0]  mdl_aging = vmlt_pkg::AGING_RESET;
    logic                        tbl_valid [TE];
    logic [vmlt_pkg::VLAN_W-1:0] tbl_vlan [TE];
    logic [vmlt_pkg::MAC_W-1:0]  tbl_mac [TE];
    logic                        tbl_static [TE];
    logic [vmlt_pkg::AGE_W-1:0]  tbl_age [TE];
    logic [PPE-1:0]              tbl_slots [TE];
    logic [vmlt_pkg::PORT_W-1:0] tbl_port [TE][PPE];
    logic [vmlt_pkg::IP_W-1:0]   tbl_ip [TE][PPE];

    t_fwd_reply pending_replies[$];
    int mismatches = 0;
    int cycles = 0;
    int burst_left = 0;
    int stall_style = 0;
    int hold_left = 0;
    bit hold_req = 0;
    int stall_phase = 0;

    initial begin
        for (int e = 0; e < TE; e++) tbl_valid[e] = 1'b0;
    end

    function automatic t_fwd_reply reply(logic [vmlt_pkg::STAT_W-1:0] st,
                                         logic [vmlt_pkg::CNT_W-1:0] rc);
        t_fwd_reply r;
        r = '{st, 1'b0, '0, '0, '0, 1'b0, rc, 1'b1};
        return r;
    endfunction

    function automatic int find_entry(logic [vmlt_pkg::VLAN_W-1:0] v,
                                      logic [vmlt_pkg::MAC_W-1:0] m);
        for (int e = 0; e < TE; e++)
            if (tbl_valid[e] && tbl_vlan[e] == v && tbl_mac[e] == m) return e;
        return -1;
    endfunction

    function automatic logic [vmlt_pkg::STAT_W-1:0] learn_station(t_fwd_cmd c);
        int e;
        int f;
        if (!mdl_mask[c.port]) return vmlt_pkg::ST_PORT_ABS;
        e = find_entry(c.vlan, c.mac);
        if (e >= 0) begin
            f = -1;
            for (int s = 0; s < PPE; s++) begin
                if (tbl_slots[e][s]) begin
                    if (tbl_port[e][s] == c.port) return vmlt_pkg::ST_OK;
                end else if (f < 0) begin
                    f = s;
                end
            end
            if (f < 0) return vmlt_pkg::ST_NO_SLOT;
            tbl_slots[e][f] = 1'b1;
            tbl_port[e][f] = c.port;
            tbl_ip[e][f] = c.ip;
            return vmlt_pkg::ST_OK;
        end
        for (e = 0; e < TE; e++)
            if (!tbl_valid[e]) break;
        if (e >= TE) return vmlt_pkg::ST_FULL;
        tbl_valid[e] = 1'b1;
        tbl_vlan[e] = c.vlan;
        tbl_mac[e] = c.mac;
        tbl_static[e] = c.make_static;
        tbl_age[e] = c.make_static ? '0 : mdl_aging;
        tbl_slots[e] = PPE'(1);
        for (int s = 0; s < PPE; s++) begin
            tbl_port[e][s] = '0;
            tbl_ip[e][s] = '0;
        end
        tbl_port[e][0] = c.port;
        tbl_ip[e][0] = c.ip;
        return vmlt_pkg::ST_OK;
    endfunction

    function automatic void forward_table_update(t_fwd_cmd c);
        int e;
        int n;
        logic [vmlt_pkg::CNT_W-1:0] cnt;
        t_fwd_reply r;
        cnt = '0;
        case (c.mode)
            vmlt_pkg::MODE_LEARN: pending_replies.push_back(reply(learn_station(c), '0));
            vmlt_pkg::MODE_DEL_PORT, vmlt_pkg::MODE_DEL_ENT: begin
                e = find_entry(c.vlan, c.mac);
                if (e < 0) begin
                    pending_replies.push_back(reply(vmlt_pkg::ST_NOT_FOUND, '0));
                end else begin
                    if (c.mode == vmlt_pkg::MODE_DEL_ENT) begin
                        tbl_valid[e] = 1'b0;
                    end else begin
                        for (int s = 0; s < PPE; s++) begin
                            if (tbl_slots[e][s] && tbl_port[e][s] == c.port &&
                                tbl_ip[e][s] == c.ip) begin
                                tbl_slots[e][s] = 1'b0;
                                break;
                            end
                        end
                        if (tbl_slots[e] == 0) tbl_valid[e] = 1'b0;
                    end
                    pending_replies.push_back(reply(vmlt_pkg::ST_OK, '0));
                end
            end
            vmlt_pkg::MODE_LOOKUP: begin
                e = find_entry(c.vlan, c.mac);
                if (e < 0 || tbl_slots[e] == 0) begin
                    pending_replies.push_back(
                        reply(e < 0 ? vmlt_pkg::ST_NOT_FOUND : vmlt_pkg::ST_OK, '0));
                end else begin
                    n = $countones(tbl_slots[e]);
                    for (int s = 0; s < PPE; s++) begin
                        if (tbl_slots[e][s]) begin
                            n--;
                            r.status = vmlt_pkg::ST_OK;
                            r.entry_static = tbl_static[e];
                            r.time_left = tbl_static[e] ? '0 : tbl_age[e];
                            r.port = tbl_port[e][s];
                            r.ip = tbl_ip[e][s];
                            r.port_valid = 1'b1;
                            r.removed = '0;
                            r.last = (n == 0);
                            pending_replies.push_back(r);
                        end
                    end
                end
            end
            vmlt_pkg::MODE_CLEAR, vmlt_pkg::MODE_TICK: begin
                for (e = 0; e < TE; e++) begin
                    if (tbl_valid[e] && !tbl_static[e]) begin
                        if (c.mode == vmlt_pkg::MODE_CLEAR || tbl_age[e] <= 1) begin
                            tbl_valid[e] = 1'b0;
                            cnt++;
                        end else begin
                            tbl_age[e]--;
                        end
                    end
                end
                pending_replies.push_back(reply(vmlt_pkg::ST_OK, cnt));
            end
            default: pending_replies.push_back(reply(vmlt_pkg::ST_OK, '0));
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_fwd_reply x;
        t_fwd_reply a;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            a = '{o_status, o_entry_static, o_time_left, o_out_port, o_out_remote_ip,
                  o_port_valid, o_removed_count, o_last};
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %p", a);
            end else begin
                x = pending_replies.pop_front();
                if (a !== x) begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p\n  actual %p", x, a);
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        stall_phase++;
        if (hold_req) begin
            hold_req = 0;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_style)
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ((stall_phase % 7) < 3);
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(t_fwd_cmd c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_mode <= c.mode;
        i_vlan <= c.vlan;
        i_mac_address <= c.mac;
        i_port_index <= c.port;
        i_remote_ip <= c.ip;
        i_make_static <= c.make_static;
        do @(posedge i_clk); while (o_in_stall);
        forward_table_update(c);
    endtask

    task automatic send(logic [vmlt_pkg::MODE_W-1:0] m, logic [vmlt_pkg::VLAN_W-1:0] v,
                        logic [vmlt_pkg::MAC_W-1:0] a, logic [vmlt_pkg::PORT_W-1:0] p,
                        logic [vmlt_pkg::IP_W-1:0] ip, logic st);
        t_fwd_cmd c;
        c = '{m, v, a, p, ip, st};
        send_item(c);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [vmlt_pkg::MASK_W-1:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == vmlt_pkg::CFG_MASK) mdl_mask = val;
        else mdl_aging = val[vmlt_pkg::AGE_W-1:0];
    endtask

    task automatic test_directed();
        write_reg(vmlt_pkg::CFG_MASK, '1);
        write_reg(vmlt_pkg::CFG_AGING, 64'd3);
        send(vmlt_pkg::MODE_LEARN, 12'hfff, '1, 6'd63, '1, 1'b0);
        send(vmlt_pkg::MODE_LEARN, 12'hfff, '1, 6'd0, '0, 1'b1);
        send(vmlt_pkg::MODE_LEARN, 12'hfff, '1, 6'd63, 32'h1234, 1'b0);
        send(vmlt_pkg::MODE_LEARN, 12'hfff, '1, 6'd1, 32'h1, 1'b0);
        send(vmlt_pkg::MODE_LEARN, 12'hfff, '1, 6'd2, 32'h2, 1'b0);
        send(vmlt_pkg::MODE_LEARN, 12'hfff, '1, 6'd3, 32'h3, 1'b0);
        send(vmlt_pkg::MODE_LOOKUP, 12'hfff, '1, 6'd0, '0, 1'b0);
        send(vmlt_pkg::MODE_DEL_PORT, 12'hfff, '1, 6'd1, 32'h9, 1'b0);
        send(vmlt_pkg::MODE_DEL_PORT, 12'hfff, '1, 6'd1, 32'h1, 1'b0);
        send(vmlt_pkg::MODE_LOOKUP, 12'hfff, '1, 6'd0, '0, 1'b0);
        send(vmlt_pkg::MODE_LOOKUP, 12'h000, '0, 6'd0, '0, 1'b0);
        send(vmlt_pkg::MODE_DEL_PORT, 12'h000, '0, 6'd0, '0, 1'b0);
        send(vmlt_pkg::MODE_DEL_ENT, 12'h000, '0, 6'd0, '0, 1'b0);
        send(vmlt_pkg::MODE_LEARN, 12'h000, '0, 6'd0, '0, 1'b1);
        send(vmlt_pkg::MODE_LEARN, 12'h555, 48'haaaa_5555_aaaa, 6'd21, 32'haaaa5555, 1'b0);
        send(vmlt_pkg::MODE_DEL_PORT, 12'h555, 48'haaaa_5555_aaaa, 6'd21, 32'haaaa5555, 1'b0);
        send(vmlt_pkg::MODE_TICK, '0, '0, '0, '0, 1'b0);
        send(vmlt_pkg::MODE_LOOKUP, 12'hfff, '1, 6'd0, '0, 1'b0);
        send(vmlt_pkg::MODE_TICK, '0, '0, '0, '0, 1'b0);
        send(vmlt_pkg::MODE_TICK, '0, '0, '0, '0, 1'b0);
        send(vmlt_pkg::MODE_LOOKUP, 12'h000, '0, 6'd0, '0, 1'b0);
        send(vmlt_pkg::MODE_CLEAR, '0, '0, '0, '0, 1'b0);
        send(vmlt_pkg::MODE_DEL_ENT, 12'h000, '0, 6'd0, '0, 1'b0);
        send(MODE_SPARE6, '1, '1, '1, '1, 1'b1);
        send(MODE_SPARE7, '0, '0, '0, '0, 1'b0);
    endtask

    task automatic test_port_mask();
        write_reg(vmlt_pkg::CFG_MASK, '0);
        send(vmlt_pkg::MODE_LEARN, 12'h1, 48'h1, 6'd0, 32'h1, 1'b0);
        write_reg(vmlt_pkg::CFG_MASK, 64'h8000_0000_0000_0001);
        send(vmlt_pkg::MODE_LEARN, 12'h1, 48'h1, 6'd5, 32'h1, 1'b0);
        send(vmlt_pkg::MODE_LEARN, 12'h1, 48'h1, 6'd63, 32'h1, 1'b0);
        send(vmlt_pkg::MODE_LEARN, 12'h1, 48'h1, 6'd0, 32'h2, 1'b0);
        send(vmlt_pkg::MODE_LOOKUP, 12'h1, 48'h1, 6'd0, '0, 1'b0);
        send(vmlt_pkg::MODE_DEL_ENT, 12'h1, 48'h1, 6'd0, '0, 1'b0);
    endtask

    task automatic test_table_full();
        write_reg(vmlt_pkg::CFG_MASK, '1);
        write_reg(vmlt_pkg::CFG_AGING, 64'hfffff);
        for (int k = 0; k < TE + 2; k++)
            send(vmlt_pkg::MODE_LEARN, 12'h800, 48'h10000 + 48'(k), 6'(k), 32'(k),
                 1'(k % 5 == 0));
        send(vmlt_pkg::MODE_LOOKUP, 12'h800, 48'h10001, 6'd0, '0, 1'b0);
        send(vmlt_pkg::MODE_TICK, '0, '0, '0, '0, 1'b0);
        send(vmlt_pkg::MODE_LOOKUP, 12'h800, 48'h10002, 6'd0, '0, 1'b0);
        send(vmlt_pkg::MODE_CLEAR, '0, '0, '0, '0, 1'b0);
        for (int k = 0; k < TE; k += 5)
            send(vmlt_pkg::MODE_DEL_ENT, 12'h800, 48'h10000 + 48'(k), 6'd0, '0, 1'b0);
    endtask

    task automatic random_items(int n);
        t_fwd_cmd c;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            c.mode = r < 35 ? vmlt_pkg::MODE_LEARN : r < 47 ? vmlt_pkg::MODE_DEL_PORT :
                     r < 54 ? vmlt_pkg::MODE_DEL_ENT : r < 80 ? vmlt_pkg::MODE_LOOKUP :
                     r < 83 ? vmlt_pkg::MODE_CLEAR : r < 95 ? vmlt_pkg::MODE_TICK :
                     3'($urandom_range(6, 7));
            if ($urandom_range(0, 9) == 0) begin
                c.vlan = 12'($urandom);
                c.mac = {16'($urandom), 32'($urandom)};
                c.port = 6'($urandom);
                c.ip = $urandom;
            end else begin
                c.vlan = 12'($urandom_range(0, 2)) * 12'h7ff;
                c.mac = {16'($urandom_range(0, 2)), 32'($urandom_range(0, 2))};
                c.port = 6'($urandom_range(0, 5)) * 6'd12;
                c.ip = $urandom_range(0, 1) ? 32'($urandom_range(0, 2)) : 32'hffff_ffff;
            end
            c.make_static = ($urandom_range(0, 3) == 0);
            send_item(c);
        end
    endtask

    task automatic test_random();
        stall_style = 1;
        write_reg(vmlt_pkg::CFG_AGING, 64'd5);
        random_items(40);
        hold_req = 1;
        random_items(30);
        stall_style = 2;
        write_reg(vmlt_pkg::CFG_MASK, {$urandom, $urandom});
        random_items(40);
        write_reg(vmlt_pkg::CFG_MASK, '1);
        write_reg(vmlt_pkg::CFG_AGING, 64'd1);
        stall_style = 0;
        random_items(40);
        write_reg(vmlt_pkg::CFG_AGING, 64'hfffff);
        stall_style = 1;
        random_items(36);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_port_mask();
        test_table_full();
        test_random();
        drain();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
